FILE: rtl/b64e_pkg.sv
package b64e_pkg;

  localparam int CFG_W  = 12;
  localparam int CHAR_W = 8;
  localparam int GRP_N  = 4;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;  // '='

  // One classified input byte: up to four characters to send, in order.
  typedef struct packed {
    logic [GRP_N-1:0][CHAR_W-1:0] chars;
    logic [2:0]                   cnt;  // 1..4
    logic                         fin;  // closes the message
  } grp_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

FILE: rtl/b64e_front.sv
module b64e_front
  import b64e_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte_in,
  input  logic              in_last_byte,
  output logic              in_stall,
  input  logic              q_full,
  output logic              push,
  output grp_t              push_data
);

  localparam logic [2:0] HC_NONE = 3'd0;
  localparam logic [2:0] HC_TWO  = 3'd2;
  localparam logic [2:0] HC_FOUR = 3'd4;

  logic [3:0] held_bits_r, held_bits_nxt;
  logic [2:0] held_count_r, held_count_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data      = '0;
    push_data.fin  = in_last_byte;
    held_bits_nxt  = held_bits_r;
    held_count_nxt = held_count_r;
    case (held_count_r)
      HC_TWO: begin
        push_data.chars[0] = b64_char({held_bits_r[1:0], in_byte_in[7:4]});
        if (in_last_byte) begin
          push_data.chars[1] = b64_char({in_byte_in[3:0], 2'b00});
          push_data.chars[2] = PAD_CHAR;
          push_data.cnt      = 3'd3;
        end else begin
          push_data.cnt  = 3'd1;
          held_bits_nxt  = in_byte_in[3:0];
          held_count_nxt = HC_FOUR;
        end
      end
      HC_FOUR: begin
        // twelve bits make two whole characters, nothing left over
        push_data.chars[0] = b64_char({held_bits_r, in_byte_in[7:6]});
        push_data.chars[1] = b64_char(in_byte_in[5:0]);
        push_data.cnt      = 3'd2;
        held_bits_nxt      = '0;
        held_count_nxt     = HC_NONE;
      end
      default: begin
        push_data.chars[0] = b64_char(in_byte_in[7:2]);
        if (in_last_byte) begin
          push_data.chars[1] = b64_char({in_byte_in[1:0], 4'b0000});
          push_data.chars[2] = PAD_CHAR;
          push_data.chars[3] = PAD_CHAR;
          push_data.cnt      = 3'd4;
        end else begin
          push_data.cnt  = 3'd1;
          held_bits_nxt  = {2'b00, in_byte_in[1:0]};
          held_count_nxt = HC_TWO;
        end
      end
    endcase
    if (in_last_byte) begin
      held_bits_nxt  = '0;
      held_count_nxt = HC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bits_r  <= '0;
      held_count_r <= HC_NONE;
    end else if (push) begin
      held_bits_r  <= held_bits_nxt;
      held_count_r <= held_count_nxt;
    end
  end

endmodule

FILE: rtl/b64e_queue.sv
module b64e_queue
  import b64e_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output grp_t head
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  grp_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

endmodule

FILE: rtl/b64e_back.sv
module b64e_back
  import b64e_pkg::*;
#(
  parameter int COUNT_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              head_valid,
  input  grp_t              head,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last_char,
  output logic              out_truncated
);

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic [CFG_W-1:0]      max_chars_r;
  logic [COUNT_BITS-1:0] chars_out_r, chars_out_nxt, chars_inc;
  logic                  limit_hit_r, limit_hit_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     char_r;
  logic                  last_r, trunc_r;

  logic [CMP_W-1:0] cnt_ext, inc_ext, max_ext;
  logic             blocked, out_free, emit, end_of_grp, hit, nat_last;

  assign chars_inc  = chars_out_r + COUNT_BITS'(1);
  assign cnt_ext    = CMP_W'(chars_out_r);
  assign inc_ext    = CMP_W'(chars_inc);
  assign max_ext    = CMP_W'(max_chars_r);
  assign blocked    = limit_hit_r || (cnt_ext >= max_ext);
  assign out_free   = !out_valid_r || !out_stall;
  assign emit       = head_valid && !blocked && out_free;
  assign end_of_grp = ({1'b0, idx_r} == (head.cnt - 3'd1));
  assign hit        = (inc_ext == max_ext);
  assign nat_last   = head.fin && end_of_grp;
  // at the limit the rest of the group is dropped with a single pop
  assign pop        = head_valid && (blocked || (out_free && end_of_grp));

  always_comb begin
    chars_out_nxt = chars_out_r;
    limit_hit_nxt = limit_hit_r;
    idx_nxt       = idx_r;
    if (head_valid && blocked) begin
      limit_hit_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (emit) begin
      chars_out_nxt = chars_inc;
      if (hit) begin
        limit_hit_nxt = 1'b1;
      end
      idx_nxt = end_of_grp ? 2'd0 : idx_r + 2'd1;
    end
    if (pop && head.fin) begin
      chars_out_nxt = '0;
      limit_hit_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= CFG_W'(255);
      chars_out_r <= '0;
      limit_hit_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_chars_r <= cfg_wdata;
      end
      chars_out_r <= chars_out_nxt;
      limit_hit_r <= limit_hit_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r  <= head.chars[idx_r];
      last_r  <= nat_last || hit;
      trunc_r <= hit && !nat_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;
  assign out_truncated = trunc_r;

`ifndef SYNTHESIS
  a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && trunc_r |-> last_r)
    else $error("truncated beat without last mark");

  a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, idx_r} < head.cnt))
    else $error("character index past end of group");

  a_hit_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    emit && hit && !(pop && head.fin) |=> limit_hit_r)
    else $error("limit reached but not held");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.fin |=> (chars_out_r == '0) && !limit_hit_r && (idx_r == '0))
    else $error("message state not cleared after final group");
`endif

endmodule

FILE: rtl/base64_encoder.sv
// Channel  Ports                                               Handshake
// -------  --------------------------------------------------  -------------------
// in       in_byte_in[7:0], in_last_byte                       in_valid / in_stall
// out      out_char_code[7:0], out_last_char, out_truncated    out_valid / out_stall
// cfg      cfg_wdata[11:0] (max_chars)                         cfg_we
//
// The output side sends one character per cycle unless out_stall holds it: an
// ordinary byte yields 1 or 2 characters, a final byte 2 to 4 (characters plus '='
// padding). The character stepper in the back end sets the pace; a two-entry group
// queue lets the byte side run ahead by two bytes.
// Reset (rst_n low, synchronous) empties the queue and clears message state;
// max_chars resets to 255. A stalled output holds its beat while input fills the queue.
module base64_encoder
  import b64e_pkg::*;
#(
  parameter int COUNT_BITS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_byte_in,
  input  logic              in_last_byte,
  output logic              in_stall,
  output logic              out_valid,
  output logic [CHAR_W-1:0] out_char_code,
  output logic              out_last_char,
  output logic              out_truncated,
  input  logic              out_stall,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  logic push, q_full, pop, head_valid;
  grp_t push_data, head;

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte_in   (in_byte_in),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .q_full       (q_full),
    .push         (push),
    .push_data    (push_data)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64e_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char),
    .out_truncated (out_truncated)
  );

endmodule
